>>> design/fir_ch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ch_pkg
// Shared widths, request codes and defaults for the circular-history FIR filter.
// ----------------------------------------------------------------------------
package fir_ch_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int TC_W    = 7;
  localparam int CIDX_W  = 7;
  localparam int COEF_W  = 18;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = COEF_W + SMP_W;

  // request codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // parameter defaults
  localparam int TAPS_DEF       = 127;
  localparam int HIST_DEPTH_DEF = 256;

  // tap count after reset
  localparam logic [TC_W-1:0] TAP_COUNT_RST = 7'd127;

  // q.15 rounding
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 16384;

  // output range
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

endpackage : fir_ch_pkg
`default_nettype wire

>>> design/fir_filter_circular_history.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_circular_history
// Direct-form FIR filter with a circular sample history held in block memory
// and one shared multiply-accumulate walking the taps.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A coefficient load or an unused code leaves
// the block idle. A filter request reads tap_count (forced odd, capped at TAPS)
// taps, one tap per cycle through the single read port of each memory, followed
// by the read, multiply, accumulate, rounding and saturation stages. A history
// clear, and the sweep after reset, hold in_stall high while zeros are written to
// every history entry, one entry per cycle; after reset the coefficients are
// zeroed in the same sweep. A finished result waits in the output register, and
// the next request is taken while it waits. The user must write tap_count only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fir_filter_circular_history #(
  parameter int TAPS          = fir_ch_pkg::TAPS_DEF,
  parameter int HISTORY_DEPTH = fir_ch_pkg::HIST_DEPTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_wr_en,
  input  wire        [fir_ch_pkg::TC_W-1:0]     cfg_wr_data,
  // request channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire        [fir_ch_pkg::OP_W-1:0]     in_op,
  input  wire        [fir_ch_pkg::CIDX_W-1:0]   in_coef_index,
  input  wire signed [fir_ch_pkg::COEF_W-1:0]   in_coef_value,
  input  wire signed [fir_ch_pkg::SMP_W-1:0]    in_sample,
  input  wire                                   in_block_end,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [fir_ch_pkg::SMP_W-1:0]   out_filtered,
  output logic                                  out_saturated,
  output logic                                  out_block_end_out
);
  import fir_ch_pkg::*;

  localparam int HW     = $clog2(HISTORY_DEPTH);
  localparam int CIW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SWEEP  = (HISTORY_DEPTH > TAPS) ? HISTORY_DEPTH : TAPS;
  localparam int SW_W   = (SWEEP > 1) ? $clog2(SWEEP) : 1;
  localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);
  localparam int RND_W  = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] BIAS_POS = ACC_W'(ROUND_HALF);
  localparam logic signed [ACC_W-1:0] BIAS_NEG = ACC_W'(ROUND_HALF - 1);
  localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(OUT_MAX);
  localparam logic signed [RND_W-1:0] RND_MIN  = RND_W'(OUT_MIN);

  // state codes
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [SW_W-1:0]          clr_cnt_r;
  logic                     clr_coef_r;
  logic [HW-1:0]            ptr_r;
  logic [TC_W-1:0]          tap_r;
  logic [TC_W-1:0]          last_r;
  logic [TC_W-1:0]          tap_count_r;
  logic                     bend_r;
  logic                     rd_v_r, prd_v_r;
  logic                     out_valid_r;

  logic signed [SMP_W-1:0]  hist_mem [HISTORY_DEPTH];
  logic signed [COEF_W-1:0] coef_mem [TAPS];
  logic signed [SMP_W-1:0]  hist_rd_r;
  logic signed [COEF_W-1:0] coef_rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RND_W-1:0]  rnd_r;
  logic signed [SMP_W-1:0]  filt_r;
  logic                     sat_r;
  logic                     bend_out_r;

  logic                     in_acc, slot_free, sweep_done, pipe_empty;
  logic                     hist_we, coef_we;
  logic [HW-1:0]            hist_wa, hist_ra, ptr_inc;
  logic signed [SMP_W-1:0]  hist_wd;
  logic [CIW-1:0]           coef_wa, coef_ra;
  logic signed [COEF_W-1:0] coef_wd;
  logic [TC_W-1:0]          tc_odd, taps_eff;
  logic signed [ACC_W-1:0]  acc_biased;
  logic                     sat_hi, sat_lo;

  // handshake
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign slot_free  = !out_valid_r || !out_stall;
  assign sweep_done = (clr_cnt_r == SW_W'(SWEEP - 1));
  assign pipe_empty = !rd_v_r && !prd_v_r;
  assign ptr_inc    = ptr_r + 1'b1;

  // effective tap count: odd, capped at TAPS
  always_comb begin
    tc_odd   = tap_count_r | TC_W'(1);
    taps_eff = tc_odd;
    if (int'(tc_odd) > TAPS) begin
      taps_eff = TC_W'(TAPS);
    end
  end

  // history write port: clearing sweep or new sample
  always_comb begin
    hist_we = 1'b0;
    hist_wa = ptr_inc;
    hist_wd = in_sample;
    if (state_r == ST_CLEAR) begin
      hist_we = 1'b1;
      hist_wa = HW'(clr_cnt_r);
      hist_wd = '0;
    end else if (in_acc && in_op == OP_FILTER) begin
      hist_we = 1'b1;
    end
  end

  // coefficient write port: reset sweep or load request
  always_comb begin
    coef_we = 1'b0;
    coef_wa = CIW'(in_coef_index);
    coef_wd = in_coef_value;
    if (state_r == ST_CLEAR) begin
      if (clr_coef_r && int'(clr_cnt_r) < TAPS) begin
        coef_we = 1'b1;
        coef_wa = CIW'(clr_cnt_r);
        coef_wd = '0;
      end
    end else if (in_acc && in_op == OP_LOAD && int'(in_coef_index) < TAPS) begin
      coef_we = 1'b1;
    end
  end

  // read addresses walk newest sample first
  assign hist_ra = ptr_r - HW'(tap_r);
  assign coef_ra = CIW'(tap_r);

  // history memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[coef_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sweep_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && in_op == OP_FILTER) begin
          state_nxt = ST_RUN;
        end else if (in_acc && in_op == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_RUN: begin
        if (tap_r == last_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_coef_r  <= 1'b1;
      ptr_r       <= '0;
      tap_r       <= '0;
      tap_count_r <= TAP_COUNT_RST;
      rd_v_r      <= 1'b0;
      prd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == ST_RUN);
      prd_v_r <= rd_v_r;
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      // clearing sweep
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (sweep_done) begin
          clr_cnt_r  <= '0;
          clr_coef_r <= 1'b0;
        end
      end
      // new filter request advances the pointer
      if (in_acc && in_op == OP_FILTER) begin
        ptr_r <= ptr_inc;
        tap_r <= '0;
      end else if (state_r == ST_RUN) begin
        tap_r <= tap_r + 1'b1;
      end
      // result register
      if (state_r == ST_FINISH && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // rounding half away from zero: bias by one less when negative
  assign acc_biased = acc_r + (acc_r[ACC_W-1] ? BIAS_NEG : BIAS_POS);
  assign sat_hi     = (rnd_r > RND_MAX);
  assign sat_lo     = (rnd_r < RND_MIN);

  // multiply-accumulate and output datapath
  always_ff @(posedge clk) begin
    prod_r <= coef_rd_r * hist_rd_r;
    if (in_acc && in_op == OP_FILTER) begin
      acc_r  <= '0;
      last_r <= taps_eff - 1'b1;
      bend_r <= in_block_end;
    end else if (prd_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_DRAIN && pipe_empty) begin
      rnd_r <= RND_W'(acc_biased >>> FRAC_BITS);
    end
    if (state_r == ST_FINISH && slot_free) begin
      sat_r      <= sat_hi || sat_lo;
      bend_out_r <= bend_r;
      if (sat_hi) begin
        filt_r <= SMP_W'(OUT_MAX);
      end else if (sat_lo) begin
        filt_r <= SMP_W'(OUT_MIN);
      end else begin
        filt_r <= SMP_W'(rnd_r);
      end
    end
  end

  assign out_filtered      = filt_r;
  assign out_saturated     = sat_r;
  assign out_block_end_out = bend_out_r;

`ifndef SYNTH
  // reset always starts a clearing sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("no clearing sweep after reset");

  // a result appears only as a filter request completes
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result without completed filter request");

  // tap walk never passes the last tap in use
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (tap_r <= last_r))
    else $error("tap index beyond tap count");

  // saturation flag implies a clamped value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_filtered == 16'sh7fff || out_filtered == 16'sh8000))
    else $error("saturated result not at range limit");
`endif

endmodule : fir_filter_circular_history
`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular-history FIR filter. A queue of
// requests feeds a clocked driver. Accepted requests update a bench-side
// copy of the history, coefficients and write pointer as needed, and filter
// requests add their expected output sample to a queue. A clocked monitor
// checks each result against the oldest entry in that queue, field by field.
// The run steps through several tap counts and idling mixes, and includes one
// long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import fir_ch_pkg::*;

  localparam int TAPS           = TAPS_DEF;
  localparam int HIST_DEPTH     = HIST_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASES         = 6;
  localparam int RANDOM_PER_PH  = 140;
  // a history clear keeps the block busy while it zeroes the history
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_AT        = 360;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SMP_W-1:0]  sample;
    logic                     block_end;
  } fir_req_t;

  typedef struct {
    logic signed [SMP_W-1:0] filtered;
    logic                    saturated;
    logic                    block_end_out;
  } fir_out_t;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [TC_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_filtered;
  logic out_saturated;
  logic out_block_end_out;
  fir_req_t cur_req = '{default: '0};

  // bench-side filter state
  logic signed [SMP_W-1:0]  hist_mem [0:HIST_DEPTH-1];
  logic signed [COEF_W-1:0] coef_mem [0:TAPS-1];
  int                       wr_ptr;
  logic [TC_W-1:0]          tap_setting;

  fir_req_t pending_reqs[$];
  fir_out_t expected_samples[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_accepted = 0;
  int n_filters = 0;
  int n_clears = 0;
  int n_results = 0;
  int n_saturated = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tap_plan [PHASES];

  always #4 clk = ~clk;

  fir_filter_circular_history DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (cur_req.op),
    .in_coef_index     (cur_req.coef_index),
    .in_coef_value     (cur_req.coef_value),
    .in_sample         (cur_req.sample),
    .in_block_end      (cur_req.block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered      (out_filtered),
    .out_saturated     (out_saturated),
    .out_block_end_out (out_block_end_out)
  );

  // mismatch reporting
  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= PRINT_CAP) begin
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    end
  endtask

  // apply one accepted request to the bench state, queue any output sample
  task automatic apply_request(input fir_req_t r);
    int       taps;
    int       p;
    longint   acc;
    longint   mag;
    longint   res;
    fir_out_t e;
    acc = 0;
    case (r.op)
      OP_LOAD: begin
        if (r.coef_index < TAPS) coef_mem[r.coef_index] = r.coef_value;
      end
      OP_CLEAR: begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        n_clears++;
      end
      OP_FILTER: begin
        taps = int'(tap_setting) | 1;
        if (taps > TAPS) taps = TAPS;
        wr_ptr = (wr_ptr + 1) & (HIST_DEPTH - 1);
        hist_mem[wr_ptr] = r.sample;
        // newest sample first, walking back round the history
        p = wr_ptr;
        for (int i = 0; i < taps; i++) begin
          acc += longint'(coef_mem[i]) * longint'(hist_mem[p]);
          p = (p - 1) & (HIST_DEPTH - 1);
        end
        // round half away from zero out of q.15, then saturate
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + ROUND_HALF) >>> FRAC_BITS;
        res = (acc < 0) ? -mag : mag;
        e.saturated = 1'b0;
        if (res > OUT_MAX) begin
          res = OUT_MAX;
          e.saturated = 1'b1;
        end else if (res < OUT_MIN) begin
          res = OUT_MIN;
          e.saturated = 1'b1;
        end
        e.filtered = SMP_W'(res);
        e.block_end_out = r.block_end;
        expected_samples.push_back(e);
        n_filters++;
      end
      default: ;
    endcase
  endtask

  function automatic fir_req_t make_req(input logic [OP_W-1:0] op, input int idx, input int val,
                                        input int smp, input bit bend);
    fir_req_t r;
    r.op = op;
    r.coef_index = CIDX_W'(idx);
    r.coef_value = COEF_W'(val);
    r.sample = SMP_W'(smp);
    r.block_end = bend;
    return r;
  endfunction

  // random requests: mostly filtering, with loads, clears and the unused code
  task automatic queue_random(input int count, input int taps_in_use);
    fir_req_t r;
    int       pick;
    int       v;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 62) r.op = OP_FILTER;
      else if (pick < 88) r.op = OP_LOAD;
      else if (pick < 94) r.op = OP_CLEAR;
      else r.op = OP_UNUSED;
      if ($urandom_range(1)) r.coef_index = CIDX_W'($urandom_range(127));
      else r.coef_index = CIDX_W'($urandom_range(taps_in_use - 1));
      case ($urandom_range(5))
        0: r.coef_value = COEF_W'($urandom());
        1: r.coef_value = $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
        2: begin
          v = int'($urandom_range(65535)) - 32768;
          r.coef_value = COEF_W'(v);
        end
        default: begin
          v = int'($urandom_range(4095)) - 2048;
          r.coef_value = COEF_W'(v);
        end
      endcase
      case ($urandom_range(9))
        0: r.sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1: r.sample = '0;
        default: r.sample = SMP_W'($urandom());
      endcase
      r.block_end = ($urandom_range(7) == 0);
      pending_reqs.push_back(r);
    end
  endtask

  // zeros, extremes, every request code, rounding halves, ignored index
  task automatic queue_directed();
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 32767, 1'b1));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 131071, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_LOAD, 126, -131072, 0, 1'b1));
    pending_reqs.push_back(make_req(OP_LOAD, 127, 77, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_UNUSED, 127, -1, -1, 1'b1));
    pending_reqs.push_back(make_req(OP_FILTER, 5, 0, 32767, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, -32768, 1'b1));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 1, 1'b0));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 16384, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 1, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, -1, 1'b1));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 16383, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 1, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, -1, 1'b0));
    pending_reqs.push_back(make_req(OP_LOAD, 1, -32768, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, -32768, 1'b1));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 32767, 1'b0));
    pending_reqs.push_back(make_req(OP_LOAD, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_LOAD, 126, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(OP_FILTER, 0, 0, 0, 1'b0));
  endtask

  // request driver
  always @(posedge clk) begin
    fir_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          cur_req <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall, with one long hold once the run is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    fir_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result, filtered", int'(out_filtered), 0);
      end else begin
        want = expected_samples.pop_front();
        if (out_filtered !== want.filtered)
          report_mismatch("filtered", int'(out_filtered), int'(want.filtered));
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", int'(out_saturated), int'(want.saturated));
        if (out_block_end_out !== want.block_end_out)
          report_mismatch("block_end_out", int'(out_block_end_out), int'(want.block_end_out));
        if (want.saturated) n_saturated++;
      end
      n_results++;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sequence of phases
  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    wr_ptr = 0;
    tap_setting = TAP_COUNT_RST;
    tap_plan = '{127, 1, 0, 2, 64, 127};
    tap_plan[4] = $urandom_range(3, 126);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 52 : 0;
      recv_stall_pct = (ph < 2) ? 52 : (ph < 4) ? 18 : 0;
      // tap count is only written while the block is idle
      if (ph > 0) begin
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= TC_W'(tap_plan[ph]);
        tap_setting = TC_W'(tap_plan[ph]);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      if (ph == 0) queue_directed();
      queue_random(RANDOM_PER_PH, tap_plan[ph] | 1);
      while (pending_reqs.size() > 0 || in_valid || expected_samples.size() > 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    $display("covered %0d requests: %0d filter, %0d clear; %0d results checked, %0d saturated",
             n_accepted, n_filters, n_clears, n_results, n_saturated);
    $display("tap counts 127, 1, 0, 2, %0d, 127 under three idling mixes and one long hold",
             tap_plan[4]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
